// ===== sv/rmv_pkg.sv =====
package rmv_pkg;

	// Sizes of the sample, the count and the fraction
	localparam int COUNT_BITS  = 32;
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 16;

	// Fixed widths of the result fields
	localparam int CNT_OUT_W = 32;
	localparam int SUM_W     = 48;
	localparam int MEAN_W    = 32;
	localparam int VAR_W     = 64;

	// Derived datapath widths
	localparam int X_W    = SAMPLE_BITS + FRAC_BITS;
	localparam int D_W    = ((X_W > MEAN_W) ? X_W : MEAN_W) + 1;
	localparam int LO_W   = (D_W + 1) / 2;
	localparam int HI_W   = D_W - LO_W;
	localparam int PROD_W = 2 * D_W;
	localparam int PEXT_W = PROD_W + VAR_W + FRAC_BITS;

	// Divider sizes: dividend and quotient share one register
	localparam int DIV_W  = VAR_W;
	localparam int STEP_W = $clog2(DIV_W + 1);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// One classified sample on its way to the back end
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [COUNT_BITS-1:0]         count;
		logic signed [SUM_W-1:0]       sum;
		logic                          ignore;
		logic                          hit_max;
	} rmv_item_t;

	// Divider request and response
	typedef struct packed {
		logic                    start;
		logic [DIV_W-1:0]        dividend;
		logic [COUNT_BITS-1:0]   divisor;
		logic [STEP_W-1:0]       steps;
	} rmv_div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} rmv_div_rsp_t;

endpackage

// ===== sv/rmv_front.sv =====
module rmv_front import rmv_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          q_full,
	output logic                          q_push,
	output rmv_item_t                     q_item
);

	logic [COUNT_BITS-1:0]   count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [COUNT_BITS-1:0]   count_nxt;
	logic signed [SUM_W-1:0] sum_nxt;
	logic                    at_max;

	assign sample_ready = !q_full;
	assign q_push       = sample_valid && sample_ready;
	assign at_max       = (count_q == COUNT_MAX);

	// Advance count and sum unless the count has topped out
	always_comb begin
		if (at_max) begin
			count_nxt = count_q;
			sum_nxt   = sum_q;
		end else begin
			count_nxt = count_q + COUNT_BITS'(1);
			sum_nxt   = sum_q + SUM_W'(sample);
		end
	end

	// Classify the word for the back end
	always_comb begin
		q_item.sample  = sample;
		q_item.count   = count_nxt;
		q_item.sum     = sum_nxt;
		q_item.ignore  = at_max;
		q_item.hit_max = !at_max && (count_nxt == COUNT_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (q_push) begin
			count_q <= count_nxt;
			sum_q   <= sum_nxt;
		end
	end

endmodule

// ===== sv/rmv_queue.sv =====
module rmv_queue import rmv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rmv_item_t push_item,
	input  logic      pop,
	output rmv_item_t head,
	output logic      full,
	output logic      empty
);

	rmv_item_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QFILL_W-1:0] fill_q;

	assign full  = (fill_q == QFILL_W'(QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + QFILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - QFILL_W'(1);
			end
		end
	end

endmodule

// ===== sv/rmv_div.sv =====
module rmv_div import rmv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  rmv_div_req_t req,
	output rmv_div_rsp_t rsp
);

	logic [COUNT_BITS-1:0] rem_q;
	logic [DIV_W-1:0]      quo_q;
	logic [COUNT_BITS-1:0] dvs_q;
	logic [STEP_W-1:0]     cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COUNT_BITS:0]   shifted;
	logic                  ge;
	logic [COUNT_BITS:0]   diff;

	// One restoring step: bring in the next dividend bit, subtract if it fits
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign ge      = (shifted >= {1'b0, dvs_q});
	assign diff    = shifted - {1'b0, dvs_q};

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	// Hold operands and shift in one quotient bit per cycle while busy
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= req.steps;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

// ===== sv/rmv_back.sv =====
module rmv_back import rmv_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rmv_item_t                 q_head,
	input  logic                      q_empty,
	output logic                      q_pop,
	output rmv_div_req_t              div_req,
	input  rmv_div_rsp_t              div_rsp,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic [CNT_OUT_W-1:0]      sample_count,
	output logic signed [SUM_W-1:0]   sample_sum,
	output logic signed [MEAN_W-1:0]  running_mean,
	output logic [VAR_W-1:0]          sample_variance,
	output logic                      saturated
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_START1 = 11'b000_0000_0010,
		S_DIV1   = 11'b000_0000_0100,
		S_D2     = 11'b000_0000_1000,
		S_MUL0   = 11'b000_0001_0000,
		S_MUL1   = 11'b000_0010_0000,
		S_MSUM   = 11'b000_0100_0000,
		S_M2     = 11'b000_1000_0000,
		S_START2 = 11'b001_0000_0000,
		S_DIV2   = 11'b010_0000_0000,
		S_DONE   = 11'b100_0000_0000
	} state_t;

	state_t                   state_q;
	rmv_item_t                cur_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic [VAR_W-1:0]         m2_q;
	logic [VAR_W-1:0]         var_q;
	logic                     sat_q;
	logic                     d_neg_q;
	logic                     d2_neg_q;
	logic [D_W-1:0]           mag_d_q;
	logic [D_W-1:0]           mag_d2_q;
	logic [D_W+LO_W-1:0]      pp_lo_q;
	logic [D_W+HI_W-1:0]      pp_hi_q;
	logic [PROD_W-1:0]        prod_q;

	logic signed [X_W-1:0]    x_c;
	logic signed [D_W-1:0]    delta_c;
	logic [D_W-1:0]           mag_c;
	logic [D_W-1:0]           qmag_c;
	logic signed [D_W-1:0]    q_c;
	logic signed [D_W:0]      nm_c;
	logic signed [MEAN_W-1:0] nm_clamp_c;
	logic [PEXT_W-1:0]        pext_c;
	logic [VAR_W-1:0]         term_c;
	logic                     over_c;
	logic [VAR_W-1:0]         m2_nxt;
	logic                     m2_sat;
	logic                     load_out;

	// Sample as fixed point and its distance from the current mean
	assign x_c     = {cur_q.sample, {FRAC_BITS{1'b0}}};
	assign delta_c = D_W'(x_c) - D_W'(mean_q);
	assign mag_c   = delta_c[D_W-1] ? D_W'(-delta_c) : D_W'(delta_c);

	// Signed quotient and the clamped new mean
	assign qmag_c = div_rsp.quotient[D_W-1:0];
	assign q_c    = d_neg_q ? D_W'(-signed'(qmag_c)) : signed'(qmag_c);
	assign nm_c   = (D_W+1)'(mean_q) + (D_W+1)'(q_c);
	always_comb begin
		if ((&nm_c[D_W:MEAN_W-1]) || !(|nm_c[D_W:MEAN_W-1])) begin
			nm_clamp_c = nm_c[MEAN_W-1:0];
		end else if (nm_c[D_W]) begin
			nm_clamp_c = {1'b1, {(MEAN_W-1){1'b0}}};
		end else begin
			nm_clamp_c = {1'b0, {(MEAN_W-1){1'b1}}};
		end
	end

	// Drop the fraction of the product and flag a term beyond the sum width
	assign pext_c = PEXT_W'(prod_q);
	assign term_c = pext_c[FRAC_BITS +: VAR_W];
	assign over_c = |pext_c[PEXT_W-1:VAR_W+FRAC_BITS];

	// Update the squared-deviation sum with clamping and saturation
	always_comb begin
		m2_sat = 1'b0;
		if (d_neg_q != d2_neg_q) begin
			m2_nxt = (over_c || term_c > m2_q) ? '0 : m2_q - term_c;
		end else if (over_c || term_c > ~m2_q) begin
			m2_nxt = '1;
			m2_sat = 1'b1;
		end else begin
			m2_nxt = m2_q + term_c;
		end
	end

	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign load_out = (state_q == S_DONE) && (!result_valid || result_ready);

	// Issue divider work: delta over count, then squared-deviation sum over count minus one
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = DIV_W'(mag_c) << (DIV_W - D_W);
		div_req.divisor  = cur_q.count;
		div_req.steps    = STEP_W'(D_W);
		case (state_q)
			S_START1: begin
				div_req.start = 1'b1;
			end
			S_START2: begin
				div_req.start    = 1'b1;
				div_req.dividend = m2_q;
				div_req.divisor  = cur_q.count - COUNT_BITS'(1);
				div_req.steps    = STEP_W'(DIV_W);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// Hold the working word and the partial products
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cur_q <= q_head;
			end
			S_START1: begin
				d_neg_q <= delta_c[D_W-1];
				mag_d_q <= mag_c;
			end
			S_D2: begin
				d2_neg_q <= delta_c[D_W-1];
				mag_d2_q <= mag_c;
			end
			S_MUL0: begin
				pp_lo_q <= (D_W+LO_W)'(mag_d_q) * (D_W+LO_W)'(mag_d2_q[LO_W-1:0]);
			end
			S_MUL1: begin
				pp_hi_q <= (D_W+HI_W)'(mag_d_q) * (D_W+HI_W)'(mag_d2_q[D_W-1:LO_W]);
			end
			S_MSUM: begin
				prod_q <= PROD_W'(pp_lo_q) + (PROD_W'(pp_hi_q) << LO_W);
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	// Sequence one word and update the running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mean_q       <= '0;
			m2_q         <= '0;
			var_q        <= '0;
			sat_q        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (load_out) begin
				result_valid <= 1'b1;
			end else if (result_valid && result_ready) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= q_head.ignore ? S_DONE : S_START1;
					end
				end
				S_START1: begin
					state_q <= S_DIV1;
				end
				S_DIV1: begin
					if (div_rsp.done) begin
						mean_q  <= nm_clamp_c;
						state_q <= S_D2;
					end
				end
				S_D2: begin
					state_q <= S_MUL0;
				end
				S_MUL0: begin
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					state_q <= S_MSUM;
				end
				S_MSUM: begin
					state_q <= S_M2;
				end
				S_M2: begin
					m2_q    <= m2_nxt;
					sat_q   <= sat_q | m2_sat | cur_q.hit_max;
					state_q <= (cur_q.count > COUNT_BITS'(1)) ? S_START2 : S_DONE;
				end
				S_START2: begin
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					if (div_rsp.done) begin
						var_q   <= div_rsp.quotient;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Drive the result word
	always_ff @(posedge clk) begin
		if (load_out) begin
			sample_count    <= CNT_OUT_W'(cur_q.count);
			sample_sum      <= cur_q.sum;
			running_mean    <= mean_q;
			sample_variance <= var_q;
			saturated       <= sat_q;
		end
	end

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV1 || state_q == S_DIV2))
		else $error("divider finished with no division pending");

	a_var_only_on_div: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == S_DIV2 && div_rsp.done) |=> $stable(var_q))
		else $error("variance changed outside its division");

	a_sat_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |=> sat_q)
		else $error("saturation flag cleared");

endmodule

// ===== sv/running_mean_variance.sv =====
// Running mean and variance by Welford's method. Each sample word yields one
// result word with the updated count, sum, mean (16 fraction bits) and sample
// variance (16 fraction bits); the variance is refreshed from the second sample
// on. A front end keeps count and sum and passes classified words through a
// two-word queue to a back end that owns mean, squared-deviation sum and
// variance. In the back end, one shared radix-2 divider works out delta over
// count and then the squared sum over count minus one, one quotient bit per
// cycle, alongside sequencing states and a two-part multiply. The first sample
// skips the second division; once the count reaches its maximum, samples are
// ignored and the held values return with saturated set.
module running_mean_variance import rmv_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [CNT_OUT_W-1:0]          sample_count,
	output logic signed [SUM_W-1:0]       sample_sum,
	output logic signed [MEAN_W-1:0]      running_mean,
	output logic [VAR_W-1:0]              sample_variance,
	output logic                          saturated
);

	rmv_item_t    push_item;
	rmv_item_t    head;
	logic         push;
	logic         pop;
	logic         full;
	logic         empty;
	rmv_div_req_t div_req;
	rmv_div_rsp_t div_rsp;

	rmv_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.q_full       (full),
		.q_push       (push),
		.q_item       (push_item)
	);

	rmv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	rmv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rmv_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_head          (head),
		.q_empty         (empty),
		.q_pop           (pop),
		.div_req         (div_req),
		.div_rsp         (div_rsp),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.sample_count    (sample_count),
		.sample_sum      (sample_sum),
		.running_mean    (running_mean),
		.sample_variance (sample_variance),
		.saturated       (saturated)
	);

endmodule

// ===== tb/rmv_stats_monitor.sv =====
`timescale 1ns / 1ps

module rmv_stats_monitor import rmv_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	input  logic                          sample_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  logic [CNT_OUT_W-1:0]          sample_count,
	input  logic signed [SUM_W-1:0]       sample_sum,
	input  logic signed [MEAN_W-1:0]      running_mean,
	input  logic [VAR_W-1:0]              sample_variance,
	input  logic                          saturated,
	output int                            fails,
	output int                            pending
);

	localparam longint MEAN_TOP = (longint'(1) <<< (MEAN_W - 1)) - 1;
	localparam longint MEAN_BOT = -(longint'(1) <<< (MEAN_W - 1));

	typedef struct {
		logic [CNT_OUT_W-1:0]     cnt;
		logic signed [SUM_W-1:0]  total;
		logic signed [MEAN_W-1:0] mean;
		logic [VAR_W-1:0]         variance;
		logic                     sat;
	} stats_t;

	// Shadow copy of the running statistics
	logic [COUNT_BITS-1:0] n_seen;
	logic [SUM_W-1:0]      run_sum;
	longint                run_mean;
	logic [VAR_W-1:0]      m2;
	logic [VAR_W-1:0]      var_hold;
	logic                  sat_seen;

	stats_t stats_due [$];
	stats_t want;
	int     bad_words;
	int     words_out;

	// Fold one sample into the shadow state and return the updated statistics
	function automatic stats_t fold_sample(input logic signed [SAMPLE_BITS-1:0] s);
		longint          x;
		longint          delta;
		longint          nm;
		longint          delta2;
		logic [127:0]    prod;
		logic [63:0]     mag_a;
		logic [63:0]     mag_b;
		logic [63:0]     term;
		logic [64:0]     acc;
		logic            over;
		logic            neg;
		stats_t          r;
		if (n_seen != COUNT_MAX) begin
			x = longint'(s) <<< FRAC_BITS;
			n_seen = n_seen + 1'b1;
			if (n_seen == COUNT_MAX)
				sat_seen = 1'b1;
			run_sum = run_sum + SUM_W'(longint'(s));

			// Mean step truncates toward zero, then clamps to the mean range
			delta = x - run_mean;
			nm = run_mean + delta / longint'(n_seen);
			if (nm > MEAN_TOP)
				nm = MEAN_TOP;
			if (nm < MEAN_BOT)
				nm = MEAN_BOT;
			run_mean = nm;
			delta2 = x - nm;

			// Squared-deviation term on magnitudes, sign applied afterwards
			neg = (delta < 0) != (delta2 < 0);
			mag_a = (delta < 0) ? 64'(-delta) : 64'(delta);
			mag_b = (delta2 < 0) ? 64'(-delta2) : 64'(delta2);
			prod = 128'(mag_a) * 128'(mag_b);
			over = |prod[127:64+FRAC_BITS];
			term = prod[63+FRAC_BITS:FRAC_BITS];
			if (neg) begin
				if (over || term > m2)
					m2 = '0;
				else
					m2 = m2 - term;
			end else begin
				acc = {1'b0, m2} + {1'b0, term};
				if (over || acc[64]) begin
					m2 = '1;
					sat_seen = 1'b1;
				end else begin
					m2 = acc[63:0];
				end
			end

			// Refresh the variance from the second sample on
			if (n_seen > 1)
				var_hold = m2 / (VAR_W'(n_seen) - 1);
		end
		r.cnt = CNT_OUT_W'(n_seen);
		r.total = run_sum;
		r.mean = MEAN_W'(run_mean);
		r.variance = var_hold;
		r.sat = sat_seen;
		return r;
	endfunction

	// Retire result words against the oldest expectation, queue new ones
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_seen = '0;
			run_sum = '0;
			run_mean = 0;
			m2 = '0;
			var_hold = '0;
			sat_seen = 1'b0;
			stats_due.delete();
			bad_words = 0;
			words_out = 0;
			fails <= 0;
			pending <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (stats_due.size() == 0) begin
					bad_words++;
					if (bad_words <= 10)
						$display("unexpected result word %0d: count %0d sum %0d",
							words_out, sample_count, sample_sum);
				end else begin
					want = stats_due.pop_front();
					if (sample_count !== want.cnt || sample_sum !== want.total ||
						running_mean !== want.mean || sample_variance !== want.variance ||
						saturated !== want.sat) begin
						bad_words++;
						if (bad_words <= 10) begin
							$display("mismatch at word %0d (expected / actual):", words_out);
							$display("  count %0d / %0d  sum %0d / %0d",
								want.cnt, sample_count, want.total, sample_sum);
							$display("  mean %0d / %0d  variance %0d / %0d  sat %0b / %0b",
								want.mean, running_mean, want.variance, sample_variance,
								want.sat, saturated);
						end
					end
				end
				words_out++;
			end
			if (sample_valid && sample_ready)
				stats_due = {stats_due, fold_sample(sample)};
			fails <= bad_words;
			pending <= stats_due.size();
		end
	end

endmodule

// ===== tb/running_mean_variance_tb.sv =====
`timescale 1ns / 1ps

module running_mean_variance_tb;
	import rmv_pkg::*;

	typedef enum int {MIX_UNIFORM, MIX_EXTREME, MIX_NEAR_ZERO, MIX_ONE_BIT, MIX_HOLD} mix_e;

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          sample_valid = 1'b0;
	logic                          sample_ready;
	logic signed [SAMPLE_BITS-1:0] sample = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	logic [CNT_OUT_W-1:0]          sample_count;
	logic signed [SUM_W-1:0]       sample_sum;
	logic signed [MEAN_W-1:0]      running_mean;
	logic [VAR_W-1:0]              sample_variance;
	logic                          saturated;

	int fails;
	int pending;
	int tx_idle_pct = 7;
	int rx_idle_pct = 87;

	// First sample alone, a repeat, the extremes and some bit patterns
	logic signed [SAMPLE_BITS-1:0] opening [$] = {
		16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001,
		16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h00FF,
		16'hFF00, 16'h4000, 16'hC000, 16'h7FFE
	};

	running_mean_variance dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_valid    (sample_valid),
		.sample_ready    (sample_ready),
		.sample          (sample),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.sample_count    (sample_count),
		.sample_sum      (sample_sum),
		.running_mean    (running_mean),
		.sample_variance (sample_variance),
		.saturated       (saturated)
	);

	rmv_stats_monitor monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_valid    (sample_valid),
		.sample_ready    (sample_ready),
		.sample          (sample),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.sample_count    (sample_count),
		.sample_sum      (sample_sum),
		.running_mean    (running_mean),
		.sample_variance (sample_variance),
		.saturated       (saturated),
		.fails           (fails),
		.pending         (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		result_ready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
	end

	// Offer one sample word, idling first at random, and hold it until taken
	task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] val);
		while ($urandom_range(99) < tx_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= val;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
	endtask

	// Drop valid and hold off until every expected result word is back
	task automatic settle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Bursts of samples drawn from one mix at a time
	task automatic random_run(input int words);
		mix_e                          mix;
		int                            burst;
		logic signed [SAMPLE_BITS-1:0] val;
		mix = MIX_UNIFORM;
		burst = 0;
		val = '0;
		repeat (words) begin
			if (burst == 0) begin
				mix = mix_e'($urandom_range(4));
				burst = $urandom_range(1, 40);
			end
			burst--;
			case (mix)
				MIX_UNIFORM: val = SAMPLE_BITS'($urandom);
				MIX_EXTREME: val = $urandom_range(1) ? S_MAX : S_MIN;
				MIX_NEAR_ZERO: val = SAMPLE_BITS'(int'($urandom_range(64)) - 32);
				MIX_ONE_BIT: begin
					val = SAMPLE_BITS'(1) << $urandom_range(SAMPLE_BITS - 1);
					if ($urandom_range(1))
						val = ~val;
				end
				default: ;
			endcase
			push_sample(val);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i])
			push_sample(opening[i]);
		settle();

		// Slow receiver, then slow sender, then full rate
		random_run(545);
		settle();
		tx_idle_pct <= 87;
		rx_idle_pct <= 7;
		random_run(545);
		settle();
		tx_idle_pct <= 0;
		rx_idle_pct <= 0;
		random_run(545);
		settle();

		// Catch stray words after the last expected one
		repeat (150) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/rmv_pkg.sv
sv/rmv_front.sv
sv/rmv_queue.sv
sv/rmv_div.sv
sv/rmv_back.sv
sv/running_mean_variance.sv
tb/rmv_stats_monitor.sv
tb/running_mean_variance_tb.sv
